// ----- rtl/tlaik_pkg.sv -----
// shared types, constants and tables for the two-link arm inverse kinematics block
`timescale 1ns / 1ps

package tlaik_pkg;

    localparam int XY_W       = 16;
    localparam int LEN_W      = 15;
    localparam int TRIM_W     = 7;
    localparam int PULSE_W    = 12;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int SQRT_STEPS        = 32;
    localparam int CNT_W             = 6;
    localparam int ITER_W            = 5;

    localparam int CV_W    = 52;
    localparam int ANG_W   = 28;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 64;
    localparam int SQ_W    = 64;
    localparam int R2_W    = 32;
    localparam int NUM_W   = 34;
    localparam int SN_W    = 31;
    localparam int RQ_W    = 16;
    localparam int CC_W    = 47;
    localparam int SPAN_W  = 24;
    localparam int TOT_W   = 40;
    localparam int Q_W     = 22;
    localparam int QD_W    = 16;
    localparam int RECIP_SHIFT = 28;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
    localparam logic [ST_W-1:0] ST_ASIN   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ONE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_TWO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SH_TRIM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EL_TRIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 3'd5;

    localparam logic [1:0] SEL_S2       = 2'd0;
    localparam logic [1:0] SEL_AS       = 2'd1;
    localparam logic [1:0] SEL_AT       = 2'd2;
    localparam logic [1:0] SEL_SHOULDER = 2'd0;
    localparam logic [1:0] SEL_ELBOW    = 2'd1;

    localparam logic signed [ANG_W-1:0] DEG90  = 28'sd5898240;
    localparam logic signed [ANG_W-1:0] DEG180 = 28'sd11796480;
    localparam logic [SPAN_W-1:0] SPAN      = 24'd11796480;
    localparam logic [SPAN_W-1:0] HALF_SPAN = 24'd5898240;
    localparam logic [MUL_W-1:0] RECIP_180 = 32'd1491308;
    localparam logic [MUL_W-1:0] DIV_180   = 32'd180;

    localparam logic signed [CV_W-1:0] NORM_LIMIT  = 52'sh100_0000_0000;
    localparam logic signed [CV_W-1:0] NORM_COARSE = 52'sh1_0000_0000;
    localparam logic [SQ_W-1:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

    localparam logic [LEN_W-1:0]   LINK_RESET      = 15'd3456;
    localparam logic [TRIM_W-1:0]  SH_TRIM_RESET   = 7'd10;
    localparam logic [TRIM_W-1:0]  EL_TRIM_RESET   = 7'h76;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RESET = 12'd600;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RESET = 12'd2400;

    typedef struct packed {
        logic signed [XY_W-1:0] target_x;
        logic signed [XY_W-1:0] target_y;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]        status;
        logic [PULSE_W-1:0]     shoulder_pulse;
        logic [PULSE_W-1:0]     elbow_pulse;
        logic signed [XY_W-1:0] held_x;
        logic signed [XY_W-1:0] held_y;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]         link_one_length;
        logic [LEN_W-1:0]         link_two_length;
        logic signed [TRIM_W-1:0] shoulder_trim;
        logic signed [TRIM_W-1:0] elbow_trim;
        logic [PULSE_W-1:0]       pulse_min;
        logic [PULSE_W-1:0]       pulse_max;
    } cfg_t;

    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_SQ_X, OP_SQ_Y, OP_SQ_D1, OP_SQ_D2, OP_D1D2, OP_DEN,
        OP_RANGE, OP_DEN2, OP_NUM2, OP_SN_LOAD, OP_SQRT_STEP, OP_SN_SAVE,
        OP_RQ_LOAD, OP_RQ_SAVE, OP_AQ1, OP_AQ2, OP_AQ_CHK, OP_CV_LOAD, OP_CV_PRE,
        OP_CV_NORM, OP_CV_ITER, OP_CV_SAVE, OP_CC1, OP_CC2, OP_CC3, OP_CC4,
        OP_AT_VERT, OP_S1, OP_QUAD, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6,
        OP_P7, OP_DONE
    } op_t;

    typedef enum logic [5:0] {
        S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_D1, S_SQ_D2, S_D1D2, S_DEN, S_RANGE,
        S_DEN2, S_NUM2, S_SN_LOAD, S_SN_STEP, S_SN_SAVE, S_RQ_LOAD, S_RQ_STEP,
        S_RQ_SAVE, S_AQ1, S_AQ2, S_AQ_CHK, S_CV_LOAD, S_CV_PRE, S_CV_NORM,
        S_CV_ITER, S_CV_SAVE, S_CC1, S_CC2, S_CC3, S_CC4, S_AT, S_S1, S_QUAD,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        CV_IDLE, CV_LOAD, CV_PRE, CV_NORM, CV_ITER
    } cv_op_t;

    typedef struct packed {
        op_t              op;
        logic [1:0]       sel;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic range_bad;
        logic asin_bad;
        logic quad_bad;
        logic x_zero;
        logic norm_done;
    } stat_t;

    // atan(2^-i) in Q.16 degrees
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ITER_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:  v = 28'sd2949120;
            5'd1:  v = 28'sd1740967;
            5'd2:  v = 28'sd919879;
            5'd3:  v = 28'sd466945;
            5'd4:  v = 28'sd234379;
            5'd5:  v = 28'sd117304;
            5'd6:  v = 28'sd58666;
            5'd7:  v = 28'sd29335;
            5'd8:  v = 28'sd14668;
            5'd9:  v = 28'sd7334;
            5'd10: v = 28'sd3667;
            5'd11: v = 28'sd1833;
            5'd12: v = 28'sd917;
            5'd13: v = 28'sd458;
            5'd14: v = 28'sd229;
            5'd15: v = 28'sd115;
            5'd16: v = 28'sd57;
            5'd17: v = 28'sd29;
            5'd18: v = 28'sd14;
            5'd19: v = 28'sd7;
            5'd20: v = 28'sd4;
            5'd21: v = 28'sd2;
            5'd22: v = 28'sd1;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/tlaik_cordic.sv -----
// vectoring cordic unit: pre-rotation, normalisation and one micro-rotation per cycle
`timescale 1ns / 1ps

module tlaik_cordic
    import tlaik_pkg::*;
(
    input  logic                    clk,
    input  cv_op_t                  op,
    input  logic [ITER_W-1:0]       iter,
    input  logic signed [CV_W-1:0]  x_in,
    input  logic signed [CV_W-1:0]  y_in,
    output logic signed [ANG_W-1:0] angle,
    output logic                    norm_done
);

    logic signed [CV_W-1:0]  x_reg, y_reg, x_next, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic                    zero_reg, zero_next;
    logic signed [CV_W-1:0]  ay, mx, xs, ys;

    always_comb
    begin
        ay = y_reg[CV_W-1] ? -y_reg : y_reg;
        mx = (x_reg > ay) ? x_reg : ay;
        norm_done = zero_reg || (mx >= NORM_LIMIT);
        xs = x_reg >>> iter;
        ys = y_reg >>> iter;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        zero_next = zero_reg;
        case (op)
            CV_LOAD:
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = '0;
                zero_next = (x_in == '0) && (y_in == '0);
            end
            CV_PRE:
            begin
                if (x_reg[CV_W-1])
                begin
                    if (!y_reg[CV_W-1])
                    begin
                        x_next = y_reg;
                        y_next = -x_reg;
                        z_next = DEG90;
                    end
                    else
                    begin
                        x_next = -y_reg;
                        y_next = x_reg;
                        z_next = -DEG90;
                    end
                end
            end
            CV_NORM:
            begin
                // coarse steps of eight doublings while far below the limit
                if (!norm_done)
                begin
                    if (mx < NORM_COARSE)
                    begin
                        x_next = x_reg <<< 8;
                        y_next = y_reg <<< 8;
                    end
                    else
                    begin
                        x_next = x_reg <<< 1;
                        y_next = y_reg <<< 1;
                    end
                end
            end
            CV_ITER:
            begin
                if (!zero_reg)
                begin
                    if (!y_reg[CV_W-1])
                    begin
                        x_next = x_reg + ys;
                        y_next = y_reg - xs;
                        z_next = z_reg + atan_q16(iter);
                    end
                    else
                    begin
                        x_next = x_reg - ys;
                        y_next = y_reg + xs;
                        z_next = z_reg - atan_q16(iter);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        zero_reg <= zero_next;
    end

    assign angle = z_reg;

endmodule

// ----- rtl/tlaik_dp.sv -----
// datapath: shared multiplier, square root, cordic, angle and pulse arithmetic
`timescale 1ns / 1ps

module tlaik_dp
    import tlaik_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  in_item_t  in_item,
    input  cfg_t      cfg,
    output stat_t     stat,
    output out_item_t out_item
);

    logic signed [XY_W-1:0]  x_reg, y_reg, last_x_reg, last_y_reg;
    logic [PROD_W-1:0]       prod_reg, acc_reg, prod_next;
    logic [R2_W-1:0]         r2_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [R2_W-1:0]         den_reg;
    logic [ST_W-1:0]         st_reg;
    logic [SQ_W-1:0]         sq_v_reg, sq_r_reg, sq_b_reg, sq_sum;
    logic [SN_W-1:0]         sn_reg;
    logic [RQ_W-1:0]         rq_reg;
    logic [CC_W-1:0]         cc_reg;
    logic signed [ANG_W-1:0] s2_reg, as_reg, at_reg, s1_reg;
    logic [Q_W-1:0]          q_reg;
    logic [QD_W-1:0]         qd_reg;
    logic [PULSE_W-1:0]      sp_reg, ep_reg;
    out_item_t               out_reg;

    logic [MUL_W-1:0]        mul_a, mul_b;
    logic                    mul_en;
    logic signed [XY_W:0]    xe, ye;
    logic [XY_W:0]           abs_x, abs_y;
    logic [NUM_W-1:0]        abs_num;
    logic signed [CV_W-1:0]  cv_x, cv_y;
    logic signed [ANG_W-1:0] cv_angle, s1_sum, ang_sel, sh_trim_deg, el_trim_deg;
    logic                    cv_norm_done;
    cv_op_t                  cv_op;
    logic [SPAN_W-1:0]       ang_c;
    logic signed [PULSE_W:0] pdiff;
    logic [PULSE_W-1:0]      abs_pdiff;
    logic signed [TOT_W-1:0] tot;
    logic [Q_W-1:0]          rem;
    logic [QD_W-1:0]         pulse_val;
    logic [CC_W-1:0]         cc_next;

    always_comb
    begin
        xe = XY_W'(x_reg) + 17'sd0;
        ye = XY_W'(y_reg) + 17'sd0;
        xe = {x_reg[XY_W-1], x_reg};
        ye = {y_reg[XY_W-1], y_reg};
        abs_x = xe[XY_W] ? (XY_W+1)'(-xe) : xe;
        abs_y = ye[XY_W] ? (XY_W+1)'(-ye) : ye;
        abs_num = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : num_reg;
        sh_trim_deg = {{(ANG_W-TRIM_W-16){cfg.shoulder_trim[TRIM_W-1]}},
                       cfg.shoulder_trim, 16'd0};
        el_trim_deg = {{(ANG_W-TRIM_W-16){cfg.elbow_trim[TRIM_W-1]}},
                       cfg.elbow_trim, 16'd0};
        s1_sum = at_reg - as_reg + DEG90 + sh_trim_deg;
        ang_sel = (cmd.sel == SEL_ELBOW) ? s2_reg : s1_reg;
        if (ang_sel[ANG_W-1])
            ang_c = '0;
        else if (ang_sel > $signed({4'd0, SPAN}))
            ang_c = SPAN;
        else
            ang_c = ang_sel[SPAN_W-1:0];
        pdiff = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
        abs_pdiff = pdiff[PULSE_W] ? PULSE_W'(-pdiff) : pdiff[PULSE_W-1:0];
        if (pdiff[PULSE_W])
            tot = $signed({4'd0, acc_reg[35:0]}) + $signed({16'd0, HALF_SPAN})
                - $signed({4'd0, prod_reg[35:0]});
        else
            tot = $signed({4'd0, acc_reg[35:0]}) + $signed({16'd0, HALF_SPAN})
                + $signed({4'd0, prod_reg[35:0]});
        rem = q_reg - prod_reg[Q_W-1:0];
        pulse_val = (rem >= Q_W'(DIV_180)) ? qd_reg + 16'd1 : qd_reg;
        if (num_reg[NUM_W-1])
            cc_next = (acc_reg >= prod_reg) ? CC_W'(acc_reg - prod_reg)
                                            : CC_W'(prod_reg - acc_reg);
        else
            cc_next = CC_W'(acc_reg + prod_reg);
        sq_sum = sq_r_reg + sq_b_reg;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_SQ_X:  begin mul_a = MUL_W'(abs_x); mul_b = MUL_W'(abs_x); end
            OP_SQ_Y:  begin mul_a = MUL_W'(abs_y); mul_b = MUL_W'(abs_y); end
            OP_SQ_D1: begin mul_a = MUL_W'(cfg.link_one_length);
                            mul_b = MUL_W'(cfg.link_one_length); end
            OP_SQ_D2: begin mul_a = MUL_W'(cfg.link_two_length);
                            mul_b = MUL_W'(cfg.link_two_length); end
            OP_D1D2:  begin mul_a = MUL_W'(cfg.link_one_length);
                            mul_b = MUL_W'(cfg.link_two_length); end
            OP_DEN2:  begin mul_a = den_reg; mul_b = den_reg; end
            OP_NUM2:  begin mul_a = abs_num[MUL_W-1:0]; mul_b = abs_num[MUL_W-1:0]; end
            OP_AQ1, OP_CC4:
                      begin mul_a = MUL_W'(cfg.link_two_length); mul_b = MUL_W'(sn_reg); end
            OP_AQ2:   begin mul_a = MUL_W'(rq_reg) + 32'd1; mul_b = den_reg; end
            OP_CC1:   begin mul_a = MUL_W'(cfg.link_one_length); mul_b = den_reg; end
            OP_CC2:   begin mul_a = MUL_W'(cfg.link_two_length);
                            mul_b = abs_num[MUL_W-1:0]; end
            OP_P1:    begin mul_a = MUL_W'(cfg.pulse_min); mul_b = MUL_W'(SPAN); end
            OP_P2:    begin mul_a = MUL_W'(ang_c); mul_b = MUL_W'(abs_pdiff); end
            OP_P4:    begin mul_a = MUL_W'(q_reg); mul_b = RECIP_180; end
            OP_P6:    begin mul_a = MUL_W'(qd_reg); mul_b = DIV_180; end
            default:  mul_en = 1'b0;
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        cv_x = '0;
        cv_y = '0;
        case (cmd.sel)
            SEL_S2:
            begin
                cv_x = CV_W'(num_reg);
                cv_y = CV_W'({1'b0, sn_reg});
            end
            SEL_AS:
            begin
                cv_x = {5'd0, cc_reg};
                cv_y = {6'd0, prod_reg[45:0]};
            end
            default:
            begin
                cv_x = x_reg[XY_W-1] ? CV_W'(-xe) : CV_W'(xe);
                cv_y = x_reg[XY_W-1] ? CV_W'(-ye) : CV_W'(ye);
            end
        endcase
        case (cmd.op)
            OP_CV_LOAD: cv_op = CV_LOAD;
            OP_CV_PRE:  cv_op = CV_PRE;
            OP_CV_NORM: cv_op = CV_NORM;
            OP_CV_ITER: cv_op = CV_ITER;
            default:    cv_op = CV_IDLE;
        endcase
    end

    tlaik_cordic u_cordic (
        .clk       (clk),
        .op        (cv_op),
        .iter      (cmd.iter),
        .x_in      (cv_x),
        .y_in      (cv_y),
        .angle     (cv_angle),
        .norm_done (cv_norm_done)
    );

    always_comb
    begin
        stat.range_bad = (r2_reg == '0) || (den_reg == '0)
                       || (abs_num > {2'd0, den_reg});
        stat.asin_bad  = acc_reg >= prod_reg;
        stat.quad_bad  = ((s1_reg < DEG90) && x_reg[XY_W-1])
                       || ((s1_reg > DEG90) && y_reg[XY_W-1]);
        stat.x_zero    = x_reg == '0;
        stat.norm_done = cv_norm_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
        end
        else if ((cmd.op == OP_DONE) && (st_reg == ST_OK))
        begin
            last_x_reg <= x_reg;
            last_y_reg <= y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= prod_next;
        case (cmd.op)
            OP_LOAD:
            begin
                x_reg <= in_item.target_x;
                y_reg <= in_item.target_y;
                st_reg <= ST_OK;
            end
            OP_SQ_Y:  acc_reg <= prod_reg;
            OP_SQ_D1: r2_reg <= R2_W'(acc_reg + prod_reg);
            OP_SQ_D2: num_reg <= $signed({2'd0, r2_reg}) - $signed({2'd0, prod_reg[31:0]});
            OP_D1D2:  num_reg <= num_reg - $signed({2'd0, prod_reg[31:0]});
            OP_DEN:   den_reg <= {prod_reg[30:0], 1'b0};
            OP_RANGE: st_reg <= stat.range_bad ? ST_REJECT : ST_OK;
            OP_NUM2:  acc_reg <= prod_reg;
            OP_SN_LOAD:
            begin
                sq_v_reg <= acc_reg - prod_reg;
                sq_r_reg <= '0;
                sq_b_reg <= SQRT_BIT0;
            end
            OP_RQ_LOAD:
            begin
                sq_v_reg <= SQ_W'(r2_reg);
                sq_r_reg <= '0;
                sq_b_reg <= SQRT_BIT0;
            end
            OP_SQRT_STEP:
            begin
                // one result bit per step
                if (sq_v_reg >= sq_sum)
                begin
                    sq_v_reg <= sq_v_reg - sq_sum;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
                sq_b_reg <= sq_b_reg >> 2;
            end
            OP_SN_SAVE: sn_reg <= sq_r_reg[SN_W-1:0];
            OP_RQ_SAVE: rq_reg <= sq_r_reg[RQ_W-1:0];
            OP_AQ2:     acc_reg <= prod_reg;
            OP_AQ_CHK:
            begin
                if (stat.asin_bad)
                    st_reg <= ST_ASIN;
            end
            OP_CV_SAVE:
            begin
                case (cmd.sel)
                    SEL_S2:  s2_reg <= cv_angle;
                    SEL_AS:  as_reg <= cv_angle;
                    default: at_reg <= cv_angle;
                endcase
            end
            OP_CC2:     acc_reg <= prod_reg;
            OP_CC3:     cc_reg <= cc_next;
            OP_AT_VERT: at_reg <= y_reg[XY_W-1] ? -DEG90 : DEG90;
            OP_S1:
            begin
                s1_reg <= s1_sum[ANG_W-1] ? s1_sum + DEG180 : s1_sum;
                s2_reg <= s2_reg + el_trim_deg;
            end
            OP_QUAD:
            begin
                if (stat.quad_bad)
                    st_reg <= ST_REJECT;
            end
            OP_P2:  acc_reg <= prod_reg;
            OP_P3:  q_reg <= tot[TOT_W-1] ? '0 : tot[Q_W+15:16];
            OP_P5:  qd_reg <= prod_reg[RECIP_SHIFT+QD_W-1:RECIP_SHIFT];
            OP_P7:
            begin
                if (cmd.sel == SEL_ELBOW)
                    ep_reg <= pulse_val[PULSE_W-1:0];
                else
                    sp_reg <= pulse_val[PULSE_W-1:0];
            end
            OP_DONE:
            begin
                out_reg.status <= st_reg;
                if (st_reg == ST_OK)
                begin
                    out_reg.shoulder_pulse <= sp_reg;
                    out_reg.elbow_pulse <= ep_reg;
                    out_reg.held_x <= x_reg;
                    out_reg.held_y <= y_reg;
                end
                else
                begin
                    out_reg.shoulder_pulse <= '0;
                    out_reg.elbow_pulse <= '0;
                    out_reg.held_x <= last_x_reg;
                    out_reg.held_y <= last_y_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_item = out_reg;

endmodule

// ----- rtl/tlaik_ctrl.sv -----
// controller: sequences the datapath through the solve and drives the handshakes
`timescale 1ns / 1ps

module tlaik_ctrl
    import tlaik_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       sel_reg, sel_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            sel_reg <= SEL_S2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready = 1'b0;
        cmd.op = OP_NONE;
        cmd.sel = sel_reg;
        cmd.iter = cnt_reg[ITER_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_SQ_X;
                end
            end
            S_SQ_X:  begin cmd.op = OP_SQ_X;  state_next = S_SQ_Y;  end
            S_SQ_Y:  begin cmd.op = OP_SQ_Y;  state_next = S_SQ_D1; end
            S_SQ_D1: begin cmd.op = OP_SQ_D1; state_next = S_SQ_D2; end
            S_SQ_D2: begin cmd.op = OP_SQ_D2; state_next = S_D1D2;  end
            S_D1D2:  begin cmd.op = OP_D1D2;  state_next = S_DEN;   end
            S_DEN:   begin cmd.op = OP_DEN;   state_next = S_RANGE; end
            S_RANGE:
            begin
                cmd.op = OP_RANGE;
                state_next = stat.range_bad ? S_DONE : S_DEN2;
            end
            S_DEN2:  begin cmd.op = OP_DEN2;  state_next = S_NUM2; end
            S_NUM2:  begin cmd.op = OP_NUM2;  state_next = S_SN_LOAD; end
            S_SN_LOAD:
            begin
                cmd.op = OP_SN_LOAD;
                cnt_next = '0;
                state_next = S_SN_STEP;
            end
            S_SN_STEP:
            begin
                cmd.op = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = S_SN_SAVE;
            end
            S_SN_SAVE: begin cmd.op = OP_SN_SAVE; state_next = S_RQ_LOAD; end
            S_RQ_LOAD:
            begin
                cmd.op = OP_RQ_LOAD;
                cnt_next = '0;
                state_next = S_RQ_STEP;
            end
            S_RQ_STEP:
            begin
                cmd.op = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = S_RQ_SAVE;
            end
            S_RQ_SAVE: begin cmd.op = OP_RQ_SAVE; state_next = S_AQ1; end
            S_AQ1:     begin cmd.op = OP_AQ1;     state_next = S_AQ2; end
            S_AQ2:     begin cmd.op = OP_AQ2;     state_next = S_AQ_CHK; end
            S_AQ_CHK:
            begin
                cmd.op = OP_AQ_CHK;
                sel_next = SEL_S2;
                state_next = stat.asin_bad ? S_DONE : S_CV_LOAD;
            end
            S_CV_LOAD: begin cmd.op = OP_CV_LOAD; state_next = S_CV_PRE; end
            S_CV_PRE:  begin cmd.op = OP_CV_PRE;  state_next = S_CV_NORM; end
            S_CV_NORM:
            begin
                if (stat.norm_done)
                begin
                    cnt_next = '0;
                    state_next = S_CV_ITER;
                end
                else
                    cmd.op = OP_CV_NORM;
            end
            S_CV_ITER:
            begin
                cmd.op = OP_CV_ITER;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_ITERATIONS - 1))
                    state_next = S_CV_SAVE;
            end
            S_CV_SAVE:
            begin
                cmd.op = OP_CV_SAVE;
                case (sel_reg)
                    SEL_S2:  state_next = S_CC1;
                    SEL_AS:  state_next = S_AT;
                    default: state_next = S_S1;
                endcase
            end
            S_CC1: begin cmd.op = OP_CC1; state_next = S_CC2; end
            S_CC2: begin cmd.op = OP_CC2; state_next = S_CC3; end
            S_CC3: begin cmd.op = OP_CC3; state_next = S_CC4; end
            S_CC4:
            begin
                cmd.op = OP_CC4;
                sel_next = SEL_AS;
                state_next = S_CV_LOAD;
            end
            S_AT:
            begin
                // a vertical target needs no cordic pass
                if (stat.x_zero)
                begin
                    cmd.op = OP_AT_VERT;
                    state_next = S_S1;
                end
                else
                begin
                    sel_next = SEL_AT;
                    state_next = S_CV_LOAD;
                end
            end
            S_S1: begin cmd.op = OP_S1; state_next = S_QUAD; end
            S_QUAD:
            begin
                cmd.op = OP_QUAD;
                sel_next = SEL_SHOULDER;
                state_next = stat.quad_bad ? S_DONE : S_P1;
            end
            S_P1: begin cmd.op = OP_P1; state_next = S_P2; end
            S_P2: begin cmd.op = OP_P2; state_next = S_P3; end
            S_P3: begin cmd.op = OP_P3; state_next = S_P4; end
            S_P4: begin cmd.op = OP_P4; state_next = S_P5; end
            S_P5: begin cmd.op = OP_P5; state_next = S_P6; end
            S_P6: begin cmd.op = OP_P6; state_next = S_P7; end
            S_P7:
            begin
                cmd.op = OP_P7;
                if (sel_reg == SEL_SHOULDER)
                begin
                    sel_next = SEL_ELBOW;
                    state_next = S_P1;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op = OP_DONE;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/two_link_arm_inverse_kinematics.sv -----
// top level: configuration registers, controller and datapath
// Solves one target point at a time. A point rejected as the origin or out of
// reach goes from the range check straight to its result; a full solve runs
// two 32-step square roots and up to three 16-step vectoring cordic passes,
// all through one shared 32x32 multiplier and one cordic unit. A new item
// is taken while the previous result still waits in the output register.
// Configuration writes are always ready and should be made only while no
// item is in flight.
`timescale 1ns / 1ps

module two_link_arm_inverse_kinematics
    import tlaik_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_one_length <= LINK_RESET;
            cfg_reg.link_two_length <= LINK_RESET;
            cfg_reg.shoulder_trim <= SH_TRIM_RESET;
            cfg_reg.elbow_trim <= EL_TRIM_RESET;
            cfg_reg.pulse_min <= PULSE_MIN_RESET;
            cfg_reg.pulse_max <= PULSE_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LINK_ONE:  cfg_reg.link_one_length <= cfg_data[LEN_W-1:0];
                CFG_LINK_TWO:  cfg_reg.link_two_length <= cfg_data[LEN_W-1:0];
                CFG_SH_TRIM:   cfg_reg.shoulder_trim <= cfg_data[TRIM_W-1:0];
                CFG_EL_TRIM:   cfg_reg.elbow_trim <= cfg_data[TRIM_W-1:0];
                CFG_PULSE_MIN: cfg_reg.pulse_min <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX: cfg_reg.pulse_max <= cfg_data[PULSE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    tlaik_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tlaik_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .stat     (stat),
        .out_item (out_item)
    );

endmodule
